FILE: src/mssd_pkg.sv
// shared constants for the masked standard deviation block
package mssd_pkg;
	localparam int SAMPLE_W = 16;
	localparam int DEV_W = 17;
	localparam int CNT_W = 9;
	localparam logic CFG_USE_NODATA = 1'b0;
	localparam logic CFG_NODATA_VALUE = 1'b1;
endpackage

FILE: src/mssd_front.sv
// front end: masks samples and accumulates sum, sum of squares and count
module mssd_front #(
	parameter int MAX_SAMPLES = 256,
	parameter int NW = 13,
	parameter int SUM_W = 29,
	parameter int SQ_W = 44
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic signed [mssd_pkg::SAMPLE_W-1:0] sample,
	input  logic is_nan,
	input  logic last,
	input  logic use_nodata,
	input  logic [mssd_pkg::SAMPLE_W-1:0] nodata_value,
	input  logic q_full,
	output logic q_push,
	output logic signed [SUM_W-1:0] q_sum,
	output logic [SQ_W-1:0] q_sq,
	output logic [NW-1:0] q_n
);
	localparam int SAMPLE_W_L = mssd_pkg::SAMPLE_W;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0] sq_q;
	logic [NW-1:0] n_q;
	logic take, skip, add;
	logic [SAMPLE_W_L-1:0] mag;
	logic [2*SAMPLE_W_L-1:0] mag_sq;

	assign full = q_full;
	assign take = push && !full;
	assign skip = is_nan || (use_nodata && sample == nodata_value);
	assign add = !skip && (n_q < NW'(MAX_SAMPLES));
	assign mag = sample[SAMPLE_W_L-1] ? SAMPLE_W_L'(-sample) : SAMPLE_W_L'(sample);
	assign mag_sq = mag * mag;

	always_comb begin
		q_sum = sum_q;
		q_sq = sq_q;
		q_n = n_q;
		if (add) begin
			q_sum = sum_q + SUM_W'(sample);
			q_sq = sq_q + SQ_W'(mag_sq);
			q_n = n_q + NW'(1);
		end
	end
	assign q_push = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sq_q <= '0;
			n_q <= '0;
		end else if (take) begin
			if (last) begin
				sum_q <= '0;
				sq_q <= '0;
				n_q <= '0;
			end else begin
				sum_q <= q_sum;
				sq_q <= q_sq;
				n_q <= q_n;
			end
		end
	end
endmodule

FILE: src/mssd_back.sv
// back end: variance by restoring division, then bit-serial square root
module mssd_back #(
	parameter int NW = 13,
	parameter int SUM_W = 29,
	parameter int SQ_W = 44
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	output logic q_pop,
	input  logic signed [SUM_W-1:0] q_sum,
	input  logic [SQ_W-1:0] q_sq,
	input  logic [NW-1:0] q_n,
	input  logic use_nodata,
	input  logic [mssd_pkg::SAMPLE_W-1:0] nodata_value,
	output logic empty,
	input  logic pop,
	output logic signed [mssd_pkg::DEV_W-1:0] deviation,
	output logic [mssd_pkg::CNT_W-1:0] used_count
);
	localparam int NUM_W = SQ_W + NW;
	localparam int DEN_W = 2 * NW;
	localparam int ABS_W = SUM_W;
	localparam int RT_W = (NUM_W + 1) / 2;
	localparam int ST_W = 3;
	localparam int CW = $clog2(NUM_W + 1);
	localparam logic [ST_W-1:0] S_IDLE = 3'd0, S_M1 = 3'd1, S_M2 = 3'd2,
		S_DIV = 3'd3, S_SQ = 3'd4, S_OUT = 3'd5;

	logic [ST_W-1:0] st_q;
	logic [NW-1:0] n_q;
	logic [ABS_W-1:0] abs_q;
	logic [SQ_W-1:0] sqin_q;
	logic [NUM_W-1:0] a_q, b_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q, rem_q;
	logic [CW-1:0] cnt_q;
	logic [NUM_W+1:0] v_q, root_q;
	logic [NUM_W+1:0] bit_q;
	logic signed [mssd_pkg::DEV_W-1:0] dev_q;
	logic [mssd_pkg::CNT_W-1:0] cntout_q;
	logic full_q;
	logic [NUM_W:0] trial;
	logic [NUM_W+1:0] rb;

	assign q_pop = (st_q == S_IDLE) && !q_empty;
	assign empty = !full_q;
	assign deviation = dev_q;
	assign used_count = cntout_q;
	assign trial = {rem_q, a_q[NUM_W-1]};
	assign rb = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			full_q <= 1'b0;
		end else begin
			if (full_q && pop && st_q != S_OUT) full_q <= 1'b0;
			case (st_q)
				S_IDLE: if (!q_empty) begin
					n_q <= q_n;
					abs_q <= q_sum[SUM_W-1] ? ABS_W'(-q_sum) : ABS_W'(q_sum);
					sqin_q <= q_sq;
					st_q <= S_M1;
				end
				S_M1: begin
					a_q <= NUM_W'(n_q) * NUM_W'(sqin_q);
					b_q <= NUM_W'(abs_q) * NUM_W'(abs_q);
					den_q <= DEN_W'(n_q) * DEN_W'(n_q - NW'(1));
					st_q <= (n_q > NW'(1)) ? S_M2 : S_OUT;
					quo_q <= '0;
				end
				S_M2: begin
					a_q <= a_q - b_q;
					rem_q <= '0;
					cnt_q <= CW'(NUM_W);
					st_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						v_q <= (NUM_W+2)'(quo_q);
						root_q <= '0;
						bit_q <= (NUM_W+2)'(1) << (2 * RT_W);
						st_q <= S_SQ;
					end else begin
						if (trial >= (NUM_W+1)'(den_q)) begin
							rem_q <= NUM_W'(trial - (NUM_W+1)'(den_q));
							quo_q <= {quo_q[NUM_W-2:0], 1'b1};
						end else begin
							rem_q <= NUM_W'(trial);
							quo_q <= {quo_q[NUM_W-2:0], 1'b0};
						end
						a_q <= a_q << 1;
						cnt_q <= cnt_q - CW'(1);
					end
				end
				S_SQ: begin
					if (bit_q == '0) begin
						st_q <= S_OUT;
					end else begin
						if (v_q >= rb) begin
							v_q <= v_q - rb;
							root_q <= (root_q >> 1) + bit_q;
						end else begin
							root_q <= root_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				S_OUT: if (!full_q || pop) begin
					if (n_q > NW'(1)) dev_q <= mssd_pkg::DEV_W'(root_q);
					else if (use_nodata) dev_q <= mssd_pkg::DEV_W'($signed(nodata_value));
					else dev_q <= '0;
					cntout_q <= mssd_pkg::CNT_W'(n_q);
					full_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: src/masked_sample_std_deviation.sv
// masked sample standard deviation: accumulating front, divide and root back
// each pixel passes load, multiply, subtract, divide, root and output in order, or with
// under two samples load, multiply and output (defaults: 48-step divide, 25-step root)
// throughput: one sample per cycle unless full; back end takes one pixel at a time
// the front stalls whenever the two-entry queue is full
// reset zeroes accumulators, queue pointers and count, back end state and config
module masked_sample_std_deviation #(
	parameter int MAX_SAMPLES = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic signed [15:0] sample,
	input  logic is_nan,
	input  logic last,
	output logic empty,
	input  logic pop,
	output logic signed [16:0] deviation,
	output logic [8:0] used_count,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int NW = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = 16 + NW;
	localparam int SQ_W = 30 + NW;
	localparam int QW = SUM_W + SQ_W + NW;

	logic use_nodata_q;
	logic [15:0] nodata_q;
	logic f_push, q_pop;
	logic signed [SUM_W-1:0] f_sum;
	logic [SQ_W-1:0] f_sq;
	logic [NW-1:0] f_n;
	logic [QW-1:0] ent_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic [QW-1:0] head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_nodata_q <= 1'b0;
			nodata_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == mssd_pkg::CFG_USE_NODATA) use_nodata_q <= cfg_data[0];
			else nodata_q <= cfg_data;
		end
	end

	mssd_front #(.MAX_SAMPLES(MAX_SAMPLES), .NW(NW), .SUM_W(SUM_W), .SQ_W(SQ_W)) u_front (
		.clk, .arst_n, .push, .full, .sample, .is_nan, .last,
		.use_nodata(use_nodata_q), .nodata_value(nodata_q),
		.q_full(cnt_q == 2'd2), .q_push(f_push), .q_sum(f_sum), .q_sq(f_sq), .q_n(f_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (f_push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(f_push) - 2'(q_pop);
		end
	end
	always_ff @(posedge clk) if (f_push) ent_q[wr_q] <= {f_sum, f_sq, f_n};
	assign head = ent_q[rd_q];

	mssd_back #(.NW(NW), .SUM_W(SUM_W), .SQ_W(SQ_W)) u_back (
		.clk, .arst_n, .q_empty(cnt_q == 2'd0), .q_pop,
		.q_sum(head[QW-1 -: SUM_W]), .q_sq(head[NW +: SQ_W]), .q_n(head[NW-1:0]),
		.use_nodata(use_nodata_q), .nodata_value(nodata_q),
		.empty, .pop, .deviation, .used_count
	);
endmodule
